// ===== hw/rtl/cpa_pkg.sv =====
// Shared types and constants for the critical path analyzer.
// Used by cpa_seq, the top level and the bench (not by cpa_ram); depends on nothing else.
package cpa_pkg;

    localparam int MAX_V = 64;
    localparam int V_W   = $clog2(MAX_V);
    localparam int N_W   = V_W + 1;
    localparam int EA_W  = 2 * V_W;
    localparam int W_W   = 16;
    localparam int T_W   = 22;
    localparam int L_W   = 24;
    localparam int P_W   = 32;
    localparam int C_W   = 12;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
    localparam logic [C_W-1:0] C_MAX = {C_W{1'b1}};
    localparam logic [P_W-1:0] P_MAX = {P_W{1'b1}};
    localparam logic [N_W-1:0] VCOUNT_RESET = N_W'(MAX_V);

    typedef struct packed {
        logic [V_W-1:0] from_vertex;
        logic [V_W-1:0] to_vertex;
        logic [W_W-1:0] weight;
        logic           last;
    } edge_item_t;

    typedef struct packed {
        logic           has_cycle;
        logic [T_W-1:0] project_length;
        logic [C_W-1:0] critical_activity_count;
        logic [P_W-1:0] critical_path_count;
    } result_t;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
    } seq_stat_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_INDEG,
        S_POP,
        S_POPX,
        S_POPE,
        S_FWD,
        S_BPREP,
        S_BPREP2,
        S_BTOP,
        S_BTOPX,
        S_BTOPE,
        S_BWD,
        S_FINISH
    } seq_state_t;

endpackage

// ===== hw/rtl/cpa_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Generic storage used by the analyzer sequencer; no package dependency.
module cpa_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/cpa_seq.sv =====
// Sequencer and shared datapath of the critical path analyzer: edge loading,
// in-degree count, forward pass, combined backward pass, and edge memory clearing.
// Depends on cpa_pkg and cpa_ram.
module cpa_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_take,
    input  cpa_pkg::edge_item_t in_item,
    input  logic [cpa_pkg::N_W-1:0] n_act,
    input  logic                out_full,
    output cpa_pkg::seq_stat_t  stat,
    output cpa_pkg::result_t    res
);
    import cpa_pkg::*;

    seq_state_t state_reg, state_next;
    logic [V_W-1:0] iy_reg, iy_next;
    logic iss_done_reg, iss_done_next;
    logic p_valid_reg, p_valid_next;
    logic [V_W-1:0] p_y_reg, p_y_next;
    logic p_last_reg, p_last_next;
    logic [V_W-1:0] col_reg, col_next;
    logic [V_W-1:0] x_reg, x_next;
    logic [T_W-1:0] ex_reg, ex_next;
    logic [T_W-1:0] esink_reg, esink_next;
    logic signed [L_W-1:0] acc_reg, acc_next;
    logic [P_W-1:0] sum_reg, sum_next;
    logic [N_W-1:0] cnt_reg, cnt_next;
    logic [C_W-1:0] crit_reg, crit_next;
    logic [N_W-1:0] sp_reg, sp_next;
    logic [N_W-1:0] done_reg, done_next;
    logic [P_W-1:0] path0_reg, path0_next;
    logic cyc_reg, cyc_next;
    logic [EA_W-1:0] clr_reg, clr_next;
    edge_item_t item_reg, item_next;

    logic [V_W-1:0] sink;
    logic inner;

    logic e_we;
    logic [EA_W-1:0] e_waddr, e_raddr;
    logic [W_W:0] e_wdata, e_rdata;
    logic d_we;
    logic [V_W-1:0] d_waddr, d_raddr;
    logic [N_W-1:0] d_wdata, d_rdata;
    logic t_we;
    logic [V_W-1:0] t_waddr, t_raddr;
    logic [T_W-1:0] t_wdata, t_rdata;
    logic l_we;
    logic [V_W-1:0] l_waddr, l_raddr;
    logic [L_W-1:0] l_wdata, l_rdata;
    logic o_we;
    logic [V_W-1:0] o_waddr, o_raddr;
    logic [V_W-1:0] o_wdata, o_rdata;
    logic k_we;
    logic [V_W-1:0] k_waddr, k_raddr;
    logic [V_W-1:0] k_wdata, k_rdata;
    logic c_we;
    logic [V_W-1:0] c_waddr, c_raddr;
    logic [P_W-1:0] c_wdata, c_rdata;

    logic present;
    logic [W_W-1:0] ew;
    logic [N_W-1:0] cnt_sum;
    logic [N_W-1:0] deg_dec;
    logic [T_W:0] fsum;
    logic [T_W-1:0] fsat;
    logic signed [L_W:0] bt;
    logic bmatch;
    logic [P_W:0] psum;
    logic signed [L_W-1:0] acc_new;
    logic [P_W-1:0] sum_new;
    logic [C_W-1:0] crit_new;
    logic in_range;

    cpa_ram #(.ADDR_W(EA_W), .DATA_W(W_W + 1)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(N_W)) u_indeg (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(T_W)) u_early (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(L_W)) u_late (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(V_W)) u_topo (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(V_W)) u_stack (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );
    cpa_ram #(.ADDR_W(V_W), .DATA_W(P_W)) u_path (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    assign sink     = V_W'(n_act - N_W'(1));
    assign inner    = (state_reg == S_INDEG) || (state_reg == S_FWD) || (state_reg == S_BWD);
    assign present  = e_rdata[W_W];
    assign ew       = e_rdata[W_W-1:0];
    assign cnt_sum  = cnt_reg + N_W'(present);
    assign deg_dec  = d_rdata - N_W'(1);
    assign fsum     = {1'b0, ex_reg} + (T_W+1)'(ew);
    assign fsat     = fsum[T_W] ? T_MAX : fsum[T_W-1:0];
    assign bt       = $signed({l_rdata[L_W-1], l_rdata}) - $signed({{(L_W+1-W_W){1'b0}}, ew});
    assign bmatch   = ($signed({{(L_W+1-T_W){1'b0}}, ex_reg}) == bt);
    assign psum     = {1'b0, sum_reg} + {1'b0, c_rdata};
    assign in_range = ({1'b0, item_reg.from_vertex} < n_act) &&
                      ({1'b0, item_reg.to_vertex} < n_act);

    always_comb
    begin
        acc_new  = acc_reg;
        sum_new  = sum_reg;
        crit_new = crit_reg;
        if (present)
        begin
            if (bt < $signed({acc_reg[L_W-1], acc_reg}))
            begin
                acc_new = bt[L_W-1:0];
            end
            if (bmatch)
            begin
                crit_new = (crit_reg == C_MAX) ? C_MAX : crit_reg + C_W'(1);
                sum_new  = psum[P_W] ? P_MAX : psum[P_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            iy_reg       <= '0;
            iss_done_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            sp_reg       <= '0;
            done_reg     <= '0;
            cyc_reg      <= 1'b0;
            clr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iy_reg       <= iy_next;
            iss_done_reg <= iss_done_next;
            p_valid_reg  <= p_valid_next;
            p_last_reg   <= p_last_next;
            sp_reg       <= sp_next;
            done_reg     <= done_next;
            cyc_reg      <= cyc_next;
            clr_reg      <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_y_reg   <= p_y_next;
        col_reg   <= col_next;
        x_reg     <= x_next;
        ex_reg    <= ex_next;
        esink_reg <= esink_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        crit_reg  <= crit_next;
        path0_reg <= path0_next;
        item_reg  <= item_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        iy_next       = '0;
        iss_done_next = 1'b0;
        p_valid_next  = 1'b0;
        p_y_next      = p_y_reg;
        p_last_next   = 1'b0;
        col_next      = col_reg;
        x_next        = x_reg;
        ex_next       = ex_reg;
        esink_next    = esink_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        crit_next     = crit_reg;
        sp_next       = sp_reg;
        done_next     = done_reg;
        path0_next    = path0_reg;
        cyc_next      = cyc_reg;
        clr_next      = clr_reg;
        item_next     = item_reg;

        e_we = 1'b0; e_waddr = clr_reg; e_wdata = '0; e_raddr = '0;
        d_we = 1'b0; d_waddr = col_reg; d_wdata = cnt_sum; d_raddr = iy_reg;
        t_we = 1'b0; t_waddr = col_reg; t_wdata = '0; t_raddr = iy_reg;
        l_we = 1'b0; l_waddr = x_reg; l_wdata = acc_new; l_raddr = iy_reg;
        o_we = 1'b0; o_waddr = done_reg[V_W-1:0]; o_wdata = k_rdata; o_raddr = col_reg;
        k_we = 1'b0; k_waddr = sp_reg[V_W-1:0]; k_wdata = col_reg;
        k_raddr = V_W'(sp_reg - N_W'(1));
        c_we = 1'b0; c_waddr = x_reg; c_wdata = sum_new; c_raddr = iy_reg;

        stat.in_ready  = 1'b0;
        stat.res_valid = 1'b0;

        if (inner)
        begin
            iy_next       = iy_reg;
            iss_done_next = iss_done_reg;
            if (!iss_done_reg)
            begin
                iy_next       = iy_reg + V_W'(1);
                iss_done_next = (iy_reg == sink);
                p_valid_next  = 1'b1;
                p_y_next      = iy_reg;
                p_last_next   = (iy_reg == sink);
            end
            if (p_valid_reg && p_last_reg)
            begin
                iy_next       = '0;
                iss_done_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                e_we     = 1'b1;
                clr_next = clr_reg + EA_W'(1);
                if (clr_reg == {EA_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                stat.in_ready = 1'b1;
                e_raddr = {in_item.from_vertex, in_item.to_vertex};
                if (in_take)
                begin
                    item_next  = in_item;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                e_waddr = {item_reg.from_vertex, item_reg.to_vertex};
                e_wdata = {1'b1, (present && (ew < item_reg.weight)) ? ew : item_reg.weight};
                e_we    = in_range;
                if (item_reg.last)
                begin
                    sp_next    = '0;
                    done_next  = '0;
                    col_next   = '0;
                    cnt_next   = '0;
                    state_next = S_INDEG;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_INDEG:
            begin
                e_raddr = {iy_reg, col_reg};
                if (p_valid_reg)
                begin
                    cnt_next = cnt_sum;
                    if (p_last_reg)
                    begin
                        d_we     = 1'b1;
                        t_we     = 1'b1;
                        cnt_next = '0;
                        if (cnt_sum == '0)
                        begin
                            k_we    = 1'b1;
                            sp_next = sp_reg + N_W'(1);
                        end
                        if (col_reg == sink)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            col_next = col_reg + V_W'(1);
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_BPREP;
                end
                else
                begin
                    sp_next    = sp_reg - N_W'(1);
                    state_next = S_POPX;
                end
            end
            S_POPX:
            begin
                x_next     = k_rdata;
                o_we       = 1'b1;
                done_next  = done_reg + N_W'(1);
                t_raddr    = k_rdata;
                state_next = S_POPE;
            end
            S_POPE:
            begin
                ex_next    = t_rdata;
                state_next = S_FWD;
            end
            S_FWD:
            begin
                e_raddr = {x_reg, iy_reg};
                d_waddr = p_y_reg;
                d_wdata = deg_dec;
                t_waddr = p_y_reg;
                t_wdata = fsat;
                k_wdata = p_y_reg;
                if (p_valid_reg)
                begin
                    if (present)
                    begin
                        d_we = 1'b1;
                        if (deg_dec == '0)
                        begin
                            k_we    = 1'b1;
                            sp_next = sp_reg + N_W'(1);
                        end
                        t_we = (t_rdata < fsat);
                    end
                    if (p_last_reg)
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_BPREP:
            begin
                t_raddr = sink;
                if (done_reg != n_act)
                begin
                    cyc_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_BPREP2;
                end
            end
            S_BPREP2:
            begin
                esink_next = t_rdata;
                col_next   = sink;
                crit_next  = '0;
                state_next = S_BTOP;
            end
            S_BTOP:
            begin
                state_next = S_BTOPX;
            end
            S_BTOPX:
            begin
                x_next     = o_rdata;
                t_raddr    = o_rdata;
                state_next = S_BTOPE;
            end
            S_BTOPE:
            begin
                ex_next    = t_rdata;
                acc_next   = $signed({{(L_W-T_W){1'b0}}, esink_reg});
                sum_next   = '0;
                state_next = S_BWD;
            end
            S_BWD:
            begin
                e_raddr = {x_reg, iy_reg};
                if (p_valid_reg)
                begin
                    acc_next  = acc_new;
                    sum_next  = sum_new;
                    crit_next = crit_new;
                    if (p_last_reg)
                    begin
                        l_we = 1'b1;
                        c_we = 1'b1;
                        if (x_reg == sink)
                        begin
                            c_wdata = P_W'(1);
                        end
                        if (x_reg == '0)
                        begin
                            path0_next = sum_new;
                        end
                        if (col_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            col_next   = col_reg - V_W'(1);
                            state_next = S_BTOP;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_full)
                begin
                    stat.res_valid = 1'b1;
                    cyc_next       = 1'b0;
                    clr_next       = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign res.has_cycle               = cyc_reg;
    assign res.project_length          = cyc_reg ? '0 : esink_reg;
    assign res.critical_activity_count = cyc_reg ? '0 : crit_reg;
    assign res.critical_path_count     = cyc_reg ? '0 : path0_reg;

`ifndef SYNTHESIS
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_valid |-> !out_full)
        else $error("A result was produced while the output register was full.");
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= N_W'(MAX_V))
        else $error("The ready stack overflowed.");
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= N_W'(MAX_V))
        else $error("More vertices were ordered than exist.");
    a_cycle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && res.has_cycle) |->
        (res.project_length == '0 && res.critical_path_count == '0))
        else $error("A cyclic graph reported nonzero timing fields.");
    a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && !item_reg.last) |=> (state_reg == S_IDLE))
        else $error("Edge loading did not return to idle.");
`endif

endmodule

// ===== hw/rtl/critical_path_analyzer_unit.sv =====
// Critical path analyzer: edge loading, CPM analysis and result register.
// Top level; depends on cpa_pkg, cpa_seq and cpa_ram.
//
// The input channel carries one activity edge per transaction (from_vertex,
// to_vertex, weight, last). The idle state reads the stored weight of an edge
// and the load state writes the smaller weight back; in_stall is high in the
// load state. A transaction with last set also starts the analysis, which runs
// on a single shared datapath: an in-degree sweep, a forward pass and a
// backward pass, followed by one result transaction on the output channel.
// After each analysis, and after reset, the edge memory is cleared in a sweep
// over all 4096 entries during which no edge is accepted. The vertex_count
// register (reset 64) is written through cfg_we and cfg_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// If the receiver stalls, the result waits in the output register and the
// block holds before its clearing sweep until the register is free.
module critical_path_analyzer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cpa_pkg::edge_item_t         in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cpa_pkg::result_t            out_data,
    input  logic                        cfg_we,
    input  logic [cpa_pkg::N_W-1:0]     cfg_data
);
    import cpa_pkg::*;

    logic [N_W-1:0] vcount_reg;
    logic [N_W-1:0] n_act;
    logic           out_valid_reg, out_valid_next;
    result_t        out_data_reg, out_data_next;
    seq_stat_t      stat;
    result_t        res;

    assign n_act = (vcount_reg < N_W'(2)) ? N_W'(2) :
                   (vcount_reg > N_W'(MAX_V)) ? N_W'(MAX_V) : vcount_reg;

    cpa_seq u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .in_take(in_valid && stat.in_ready),
        .in_item(in_data),
        .n_act(n_act),
        .out_full(out_valid_reg),
        .stat(stat),
        .res(res)
    );

    assign in_stall  = !stat.in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (stat.res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== bench/tb.sv =====
// Testbench for the critical path analyzer: random and directed edge sets with a scoreboard.
// Depends on cpa_pkg and the critical_path_analyzer_unit RTL only.
`timescale 1ns / 1ps

module tb;
    import cpa_pkg::*;

    class cpa_scoreboard;
        bit             present [MAX_V*MAX_V];
        int unsigned    wgt [MAX_V*MAX_V];
        int unsigned    nverts;
        result_t        pending [$];
        int             errors;

        function new();
            nverts = MAX_V;
            errors = 0;
            foreach (present[i]) present[i] = 0;
        endfunction

        function void set_count(int unsigned v);
            nverts = (v < 2) ? 2 : (v > MAX_V ? MAX_V : v);
        endfunction

        function result_t analyze_graph();
            int unsigned n, sp, done, x, y, k, e, crit, sink;
            int unsigned indeg [MAX_V];
            longint unsigned early [MAX_V];
            longint late [MAX_V];
            int unsigned order [MAX_V];
            int unsigned stack [MAX_V];
            longint unsigned paths [MAX_V];
            longint unsigned t, sum;
            longint lt;
            result_t r;
            n = nverts;
            sp = 0;
            done = 0;
            crit = 0;
            sink = n - 1;
            r = '0;
            for (y = 0; y < n; y++)
            begin
                indeg[y] = 0;
                early[y] = 0;
                for (x = 0; x < n; x++)
                    if (present[x*MAX_V+y]) indeg[y]++;
            end
            for (x = 0; x < n; x++)
                if (indeg[x] == 0) stack[sp++] = x;
            while (sp > 0)
            begin
                sp--;
                x = stack[sp];
                order[done++] = x;
                for (y = 0; y < n; y++)
                begin
                    e = x*MAX_V + y;
                    if (!present[e]) continue;
                    indeg[y]--;
                    if (indeg[y] == 0 && sp < MAX_V) stack[sp++] = y;
                    t = early[x] + wgt[e];
                    if (t > T_MAX) t = T_MAX;
                    if (early[y] < t) early[y] = t;
                end
            end
            if (done < n)
            begin
                r.has_cycle = 1'b1;
                return r;
            end
            for (x = 0; x < n; x++) late[x] = early[sink];
            for (k = n; k > 0; k--)
            begin
                x = order[k-1];
                for (y = 0; y < n; y++)
                begin
                    e = x*MAX_V + y;
                    if (!present[e]) continue;
                    lt = late[y] - longint'(wgt[e]);
                    if (lt < late[x]) late[x] = lt;
                end
            end
            for (k = n; k > 0; k--)
            begin
                x = order[k-1];
                sum = 0;
                if (x == sink) sum = 1;
                else
                    for (y = 0; y < n; y++)
                    begin
                        e = x*MAX_V + y;
                        if (present[e] && longint'(early[x]) == late[y] - longint'(wgt[e]))
                        begin
                            sum += paths[y];
                            if (sum > P_MAX) sum = P_MAX;
                        end
                    end
                paths[x] = sum;
            end
            for (x = 0; x < n; x++)
                for (y = 0; y < n; y++)
                begin
                    e = x*MAX_V + y;
                    if (present[e] && longint'(early[x]) == late[y] - longint'(wgt[e])
                        && crit < C_MAX)
                        crit++;
                end
            r.project_length = early[sink][T_W-1:0];
            r.critical_activity_count = crit[C_W-1:0];
            r.critical_path_count = paths[0][P_W-1:0];
            return r;
        endfunction

        function void note_edge(edge_item_t it);
            int unsigned e;
            if (it.from_vertex < nverts && it.to_vertex < nverts)
            begin
                e = it.from_vertex*MAX_V + it.to_vertex;
                if (!present[e] || it.weight < wgt[e])
                begin
                    present[e] = 1;
                    wgt[e] = it.weight;
                end
            end
            if (it.last)
            begin
                pending.push_back(analyze_graph());
                foreach (present[i]) present[i] = 0;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.has_cycle !== exp.has_cycle)
            begin
                $error("has_cycle: expected %0d, got %0d", exp.has_cycle, got.has_cycle);
                errors++;
            end
            if (got.project_length !== exp.project_length)
            begin
                $error("project_length: expected %0d, got %0d",
                       exp.project_length, got.project_length);
                errors++;
            end
            if (got.critical_activity_count !== exp.critical_activity_count)
            begin
                $error("critical_activity_count: expected %0d, got %0d",
                       exp.critical_activity_count, got.critical_activity_count);
                errors++;
            end
            if (got.critical_path_count !== exp.critical_path_count)
            begin
                $error("critical_path_count: expected %0d, got %0d",
                       exp.critical_path_count, got.critical_path_count);
                errors++;
            end
        endfunction
    endclass

    logic           clk = 0;
    logic           rst_n = 0;
    logic           in_valid = 0;
    logic           in_stall;
    edge_item_t     in_data = '0;
    logic           out_valid;
    logic           out_stall = 0;
    result_t        out_data;
    logic           cfg_we = 0;
    logic [N_W-1:0] cfg_data = '0;

    cpa_scoreboard  sb;
    int             idle_cycles = 0;
    int             edges_sent = 0;
    int             graphs_sent = 0;
    bit             stall_random = 1;

    localparam int WATCHDOG = 200000;

    always #1 clk = ~clk;

    critical_path_analyzer_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (out_valid && !out_stall) sb.check_result(out_data);
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin : stall_gen
        int n;
        forever
        begin
            @(negedge clk);
            if (!stall_random) out_stall <= 0;
            else if (out_stall) out_stall <= ($urandom_range(0, 2) != 0);
            else if ($urandom_range(0, 3) == 0)
            begin
                n = gap_len() + 1;
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_edge(int f, int t, int w, bit lst, bit gaps);
        int g;
        edge_item_t it;
        it.from_vertex = V_W'(f);
        it.to_vertex = V_W'(t);
        it.weight = W_W'(w);
        it.last = lst;
        g = gaps ? gap_len() : 0;
        repeat (g + 1) @(negedge clk);
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_edge(it);
        edges_sent++;
        if (lst) graphs_sent++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_vertices(int v);
        drain();
        cfg_we <= 1;
        cfg_data <= N_W'(v);
        @(negedge clk);
        cfg_we <= 0;
        sb.set_count(v);
    endtask

    task automatic random_graph(int nv, bit well);
        int ne, i, f, t;
        ne = $urandom_range(1, 3 * nv);
        for (i = 0; i < ne; i++)
        begin
            f = $urandom_range(0, nv - 1);
            t = $urandom_range(0, nv - 1);
            if (well && f >= t)
            begin
                f = $urandom_range(0, nv - 2);
                t = $urandom_range(f + 1, nv - 1);
            end
            if ($urandom_range(0, 15) == 0) f = $urandom_range(0, 63);
            send_edge(f, t,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 15),
                      i == ne - 1, 1);
        end
    endtask

    initial
    begin
        int v;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        stall_random = 0;
        send_edge(0, 63, 65535, 0, 0);
        send_edge(0, 63, 100, 0, 0);
        send_edge(0, 1, 0, 0, 0);
        send_edge(1, 63, 0, 1, 0);
        set_vertices(2);
        send_edge(0, 1, 7, 0, 0);
        send_edge(1, 1, 3, 1, 0);
        send_edge(0, 1, 5, 0, 0);
        send_edge(63, 0, 5, 1, 0);
        set_vertices(0);
        send_edge(0, 1, 9, 1, 0);
        set_vertices(127);
        send_edge(0, 2, 1, 0, 0);
        send_edge(0, 3, 1, 0, 0);
        send_edge(2, 63, 1, 0, 0);
        send_edge(3, 63, 1, 0, 0);
        send_edge(63, 5, 2, 1, 0);
        for (v = 0; v < 63; v++) send_edge(v, v + 1, 65535, v == 62, 0);
        set_vertices(4);
        send_edge(0, 1, 1, 0, 0);
        set_vertices(3);
        send_edge(2, 0, 1, 0, 0);
        send_edge(0, 2, 4, 1, 0);
        stall_random = 1;

        while (edges_sent < 400)
        begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 8);
            set_vertices(v);
            repeat ($urandom_range(1, 4)) random_graph(v, $urandom_range(0, 4) != 0);
        end
        set_vertices(64);
        random_graph(64, 1);
        drain();

        $display("tb: %0d edges over %0d graphs, vertex counts 0 to 127, random stalls",
                 edges_sent, graphs_sent);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/cpa_pkg.sv
hw/rtl/cpa_ram.sv
hw/rtl/cpa_seq.sv
hw/rtl/critical_path_analyzer_unit.sv
bench/tb.sv
